@@ rtl/mickey_keystream_cipher_unit_macros.svh @@
// Assertion macros for the keystream cipher unit.
// Used by the sequencer; depends on nothing else.
`ifndef MICKEY_KEYSTREAM_CIPHER_UNIT_MACROS_SVH
`define MICKEY_KEYSTREAM_CIPHER_UNIT_MACROS_SVH

// same-cycle implication
`define MKY_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mky assertion failed");

// next-cycle implication
`define MKY_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mky assertion failed");

`endif

@@ rtl/mky_pkg.sv @@
// Shared types, constants and feedback tables for the keystream cipher unit.
// No dependencies.
`timescale 1ns / 1ps

package mky_pkg;

  localparam int NStages   = 100;
  localparam int KeyBits   = 80;
  localparam int MaxIvBits = 80;
  localparam int PreClocks = 100;
  localparam int ByteBits  = 8;
  localparam int TapCrS    = 34;
  localparam int TapCrR    = 67;
  localparam int TapCsS    = 67;
  localparam int TapCsR    = 33;
  localparam int TapMixS   = 50;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIvBits  = 2'd2;

  localparam logic KindInit = 1'b0;
  localparam logic KindData = 1'b1;

  // stage k of a register is element [k]
  typedef logic [0:NStages-1] stage_vec_t;

  localparam stage_vec_t LinTaps =
    100'b1101111001001100100111100_1001000000001100110011000_1010101010110111110001100_0000111100001111110111100;
  localparam stage_vec_t InvA =
    100'b0000110001011110100101010_1010110100100000001010101_0000101001111001010111111_1110101111110101000000110;
  localparam stage_vec_t InvB =
    100'b0101100101111001010001101_0111011110001101011100001_0001011100011111101011101_1110001000011100010011000;
  localparam stage_vec_t NlFb0 =
    100'b1111010111111110010111111_1111001100000011100100101_0100101111010101000000000_1101000110111001110011000;
  localparam stage_vec_t NlFb1 =
    100'b1110111000011101001100010_0110010110001100000110110_0010001001001011010100101_0001111011111000000100001;

  typedef struct packed {
    logic clear;
    logic step;
    logic mix;
    logic in_bit;
  } gen_ctrl_t;

  typedef struct packed {
    logic [ByteBits-1:0] out_byte;
    logic                init_done;
    logic                eom;
  } seq_result_t;

endpackage

@@ rtl/mky_gen.sv @@
// Keystream generator core: R and S registers, one generator clock per cycle while ctrl.step is set.
// Depends on mky_pkg.
`timescale 1ns / 1ps

module mky_gen import mky_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  gen_ctrl_t ctrl,
  output logic      z
);

  stage_vec_t r_r, r_nxt;
  stage_vec_t s_r, s_nxt;
  stage_vec_t r_step, s_step, s_core;
  logic       cr, cs, rin, fb_r, fb_s;

  assign z   = r_r[0] ^ s_r[0];
  assign cr  = s_r[TapCrS] ^ r_r[TapCrR];
  assign cs  = s_r[TapCsS] ^ r_r[TapCsR];
  assign rin = ctrl.mix ? (ctrl.in_bit ^ s_r[TapMixS]) : ctrl.in_bit;

  assign fb_r = r_r[NStages-1] ^ rin;
  assign fb_s = s_r[NStages-1] ^ ctrl.in_bit;

  assign r_step = {1'b0, r_r[0:NStages-2]} ^ (r_r & {NStages{cr}})
                ^ (LinTaps & {NStages{fb_r}});

  always_comb begin
    s_core = '0;
    for (int k = 1; k < NStages - 1; k++) begin
      s_core[k] = s_r[k-1] ^ ((s_r[k] ^ InvA[k]) & (s_r[k+1] ^ InvB[k]));
    end
    s_core[NStages-1] = s_r[NStages-2];
  end

  assign s_step = s_core ^ ((cs ? NlFb1 : NlFb0) & {NStages{fb_s}});

  always_comb begin
    r_nxt = r_r;
    s_nxt = s_r;
    if (ctrl.clear) begin
      r_nxt = '0;
      s_nxt = '0;
    end else if (ctrl.step) begin
      r_nxt = r_step;
      s_nxt = s_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r <= '0;
      s_r <= '0;
    end else begin
      r_r <= r_nxt;
      s_r <= s_nxt;
    end
  end

endmodule

@@ rtl/mky_seq.sv @@
// Sequencer: takes a request, drives the generator through init or one byte.
// Depends on mky_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "mickey_keystream_cipher_unit_macros.svh"

module mky_seq import mky_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [15:0]         in_iv_high,
  input  logic [63:0]         in_iv_low,
  input  logic [ByteBits-1:0] in_data_byte,
  input  logic                in_end_of_message,
  input  logic [15:0]         key_high,
  input  logic [63:0]         key_low,
  input  logic [6:0]          iv_bits,
  input  logic                out_free,
  input  logic                z,
  output gen_ctrl_t           gen_ctrl,
  output logic                done,
  output seq_result_t         result
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLEAR = 7'b0000010,
    ST_IV    = 7'b0000100,
    ST_KEY   = 7'b0001000,
    ST_PRE   = 7'b0010000,
    ST_DATA  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic [79:0]         sh_r, sh_nxt;
  logic [ByteBits-1:0] ks_r, ks_nxt;
  logic [ByteBits-1:0] data_r;
  logic                kind_r, eom_r;
  logic [6:0]          iv_n;
  logic                accept;

  assign iv_n     = (iv_bits > 7'(MaxIvBits)) ? 7'(MaxIvBits) : iv_bits;
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign done     = (state_r == ST_DONE);

  assign gen_ctrl.clear  = (state_r == ST_CLEAR);
  assign gen_ctrl.step   = (state_r == ST_IV) || (state_r == ST_KEY)
                        || (state_r == ST_PRE) || (state_r == ST_DATA);
  assign gen_ctrl.mix    = (state_r != ST_DATA);
  assign gen_ctrl.in_bit = ((state_r == ST_IV) || (state_r == ST_KEY)) ? sh_r[79] : 1'b0;

  assign result.out_byte  = (kind_r == KindInit) ? '0 : (data_r ^ ks_r);
  assign result.init_done = (kind_r == KindInit);
  assign result.eom       = eom_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sh_nxt    = sh_r;
    ks_nxt    = ks_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sh_nxt    = {in_iv_high, in_iv_low};
          cnt_nxt   = '0;
          state_nxt = (in_kind == KindInit) ? ST_CLEAR : ST_DATA;
        end
      end
      ST_CLEAR: begin
        cnt_nxt = '0;
        if (iv_n == '0) begin
          sh_nxt    = {key_high, key_low};
          state_nxt = ST_KEY;
        end else begin
          state_nxt = ST_IV;
        end
      end
      ST_IV: begin
        sh_nxt  = {sh_r[78:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(iv_n - 7'd1)) begin
          sh_nxt    = {key_high, key_low};
          cnt_nxt   = '0;
          state_nxt = ST_KEY;
        end
      end
      ST_KEY: begin
        sh_nxt  = {sh_r[78:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(KeyBits - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_PRE;
        end
      end
      ST_PRE: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(PreClocks - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DATA: begin
        ks_nxt  = {ks_r[ByteBits-2:0], z};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(ByteBits - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
    ks_r <= ks_nxt;
    if (accept) begin
      data_r <= in_data_byte;
      kind_r <= in_kind;
      eom_r  <= in_end_of_message;
    end
  end

  `MKY_ASSERT_NEXT(a_init_clears, clk, rst_n, accept && (in_kind == KindInit), state_r == ST_CLEAR)
  `MKY_ASSERT_NEXT(a_byte_len, clk, rst_n, (state_r == ST_DATA) && (cnt_r == 7'(ByteBits - 1)), done)
  `MKY_ASSERT_NEXT(a_done_hold, clk, rst_n, done && !out_free, done && $stable(result))
  `MKY_ASSERT_IMPLY(a_no_step_idle, clk, rst_n, state_r == ST_IDLE || done, !gen_ctrl.step && !gen_ctrl.clear)

endmodule

@@ rtl/mickey_keystream_cipher_unit.sv @@
// Keystream cipher unit: one request at a time; one generator clock per cycle in the IV,
// key, pre-clock and data phases. Data request: a keystream byte is shifted in bitwise,
// XORed with the data byte and registered; no new request is taken until it is registered.
// Init request: clear, then min(iv_bits, 80) IV bits, the 80 key bits and the pre-clocks.
// A result held by out_stall delays the next result.
// Reset (rst_n low, synchronous) zeroes both cipher registers and the configuration.
`timescale 1ns / 1ps

module mickey_keystream_cipher_unit import mky_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [15:0]         in_iv_high,
  input  logic [63:0]         in_iv_low,
  input  logic [ByteBits-1:0] in_data_byte,
  input  logic                in_end_of_message,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ByteBits-1:0] out_byte,
  output logic                out_init_done,
  output logic                out_end_of_message_out
);

  logic [15:0] key_high_r;
  logic [63:0] key_low_r;
  logic [6:0]  iv_bits_r;
  logic        out_valid_r;
  seq_result_t res_r;
  seq_result_t seq_res;
  gen_ctrl_t   gen_ctrl;
  logic        z, done, out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      iv_bits_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgKeyHigh: key_high_r <= cfg_data[15:0];
        CfgKeyLow:  key_low_r  <= cfg_data;
        CfgIvBits:  iv_bits_r  <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  mky_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_iv_high        (in_iv_high),
    .in_iv_low         (in_iv_low),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .key_high          (key_high_r),
    .key_low           (key_low_r),
    .iv_bits           (iv_bits_r),
    .out_free          (out_free),
    .z                 (z),
    .gen_ctrl          (gen_ctrl),
    .done              (done),
    .result            (seq_res)
  );

  mky_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (gen_ctrl),
    .z     (z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      res_r <= seq_res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_byte               = res_r.out_byte;
  assign out_init_done          = res_r.init_done;
  assign out_end_of_message_out = res_r.eom;

endmodule
